>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file t7x_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define T7X_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define T7X_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/t7x_pkg.sv
// ----------------------------------------------------------------------------
// t7x_pkg
// Types, constants and helper functions of the type-7 XOR password codec.
// ----------------------------------------------------------------------------
package t7x_pkg;

   localparam int CHAR_W     = 8;
   localparam int KEY_IDX_W  = 5;
   localparam int NIB_W      = 4;
   localparam int CSR_DATA_W = 5;
   localparam int MAX_RSP    = 4;
   localparam int RSP_CNT_W  = 3;
   localparam int RSP_PTR_W  = 2;

   localparam logic [KEY_IDX_W-1:0] KEY_LEN  = 5'd26;
   localparam logic [KEY_IDX_W-1:0] KEY_LAST = 5'd25;

   localparam logic [CHAR_W-1:0] ASCII_0 = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_9 = 8'h39;
   localparam logic [CHAR_W-1:0] ASCII_UA = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_UF = 8'h46;
   localparam logic [CHAR_W-1:0] ASCII_LA = 8'h61;
   localparam logic [CHAR_W-1:0] ASCII_LF = 8'h66;

   typedef enum logic [1:0] {
      PH_TENS  = 2'd0,
      PH_UNITS = 2'd1,
      PH_HIGH  = 2'd2,
      PH_LOW   = 2'd3
   } phase_type;

   typedef enum logic [0:0] {
      CSR_MODE = 1'b0,
      CSR_SEED = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_DECODE = 1'b0,
      MODE_ENCODE = 1'b1
   } mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              first;
      logic              final_item;
   } req_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              error;
      logic              done_res;
   } rsp_item_type;

   typedef struct packed {
      logic [RSP_CNT_W-1:0]            cnt;
      rsp_item_type [MAX_RSP-1:0]      items;
   } rsp_bundle_type;

   function automatic logic [CHAR_W-1:0] key_at(logic [KEY_IDX_W-1:0] idx);
      logic [CHAR_W-1:0] k;
      case (idx)
         5'd0:    k = 8'h2a;
         5'd1:    k = 8'h40;
         5'd2:    k = 8'h23;
         5'd3:    k = 8'h23;
         5'd4:    k = 8'h57;
         5'd5:    k = 8'h78;
         5'd6:    k = 8'h66;
         5'd7:    k = 8'h5e;
         5'd8:    k = 8'h63;
         5'd9:    k = 8'h4f;
         5'd10:   k = 8'h75;
         5'd11:   k = 8'h72;
         5'd12:   k = 8'h47;
         5'd13:   k = 8'h65;
         5'd14:   k = 8'h72;
         5'd15:   k = 8'h2a;
         5'd16:   k = 8'h6d;
         5'd17:   k = 8'h41;
         5'd18:   k = 8'h72;
         5'd19:   k = 8'h4b;
         5'd20:   k = 8'h4c;
         5'd21:   k = 8'h65;
         5'd22:   k = 8'h48;
         5'd23:   k = 8'h53;
         5'd24:   k = 8'h55;
         5'd25:   k = 8'h42;
         default: k = 8'h00;
      endcase
      return k;
   endfunction

   function automatic logic [KEY_IDX_W-1:0] step_key(logic [KEY_IDX_W-1:0] idx);
      return (idx >= KEY_LAST) ? '0 : idx + 5'd1;
   endfunction

   // value mod 26 for an 8-bit value: quotient by reciprocal 79/2048
   function automatic logic [KEY_IDX_W-1:0] mod26(logic [CHAR_W-1:0] v);
      logic [14:0] prod;
      logic [CHAR_W-1:0] q;
      logic [CHAR_W-1:0] r;
      prod = {7'd0, v} * 15'd79;
      q    = {4'd0, prod[14:11]};
      r    = v - q * 8'd26;
      return r[KEY_IDX_W-1:0];
   endfunction

   function automatic logic is_digit(logic [CHAR_W-1:0] c);
      return (c >= ASCII_0) && (c <= ASCII_9);
   endfunction

   // 0..15 for a hex character, 16 otherwise
   function automatic logic [NIB_W:0] hex_val(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = 8'd16;
      if (c >= ASCII_0 && c <= ASCII_9) begin
         d = c - ASCII_0;
      end else if (c >= ASCII_UA && c <= ASCII_UF) begin
         d = c - ASCII_UA + 8'd10;
      end else if (c >= ASCII_LA && c <= ASCII_LF) begin
         d = c - ASCII_LA + 8'd10;
      end
      return d[NIB_W:0];
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char(logic [NIB_W-1:0] v);
      return (v > 4'd9) ? ({4'd0, v} - 8'd10 + ASCII_UA) : ({4'd0, v} + ASCII_0);
   endfunction

endpackage

>>> hdl/t7x_req_if.sv
// ----------------------------------------------------------------------------
// t7x_req_if
// Input character channel: valid/ready plus one character and its markers.
// ----------------------------------------------------------------------------
interface t7x_req_if;
   logic                      valid;
   logic                      ready;
   logic [t7x_pkg::CHAR_W-1:0] char_in;
   logic                      first;
   logic                      final_item;

   modport source (output valid, output char_in, output first, output final_item,
                   input ready);
   modport sink   (input valid, input char_in, input first, input final_item,
                   output ready);
endinterface

>>> hdl/t7x_rsp_if.sv
// ----------------------------------------------------------------------------
// t7x_rsp_if
// Result channel: valid/ready plus one output character and its flags.
// ----------------------------------------------------------------------------
interface t7x_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [t7x_pkg::CHAR_W-1:0] char_out;
   logic                      run_last;
   logic                      error;
   logic                      done_res;

   modport source (output valid, output char_out, output run_last, output error,
                   output done_res, input ready);
   modport sink   (input valid, input char_out, input run_last, input error,
                   input done_res, output ready);
endinterface

>>> hdl/t7x_csr_if.sv
// ----------------------------------------------------------------------------
// t7x_csr_if
// Register write channel: valid/ready plus register index and write data.
// ----------------------------------------------------------------------------
interface t7x_csr_if;
   logic                          valid;
   logic                          ready;
   t7x_pkg::csr_index_type        index;
   logic [t7x_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/t7x_engine.sv
// ----------------------------------------------------------------------------
// t7x_engine
// Sequence state and per-character decode/encode logic; builds the results.
// ----------------------------------------------------------------------------
module t7x_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic                     restart,
   input  logic                     mode,
   input  logic [t7x_pkg::KEY_IDX_W-1:0] seed,
   input  t7x_pkg::req_item_type    item,
   output t7x_pkg::rsp_bundle_type  bundle
);
   import t7x_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [KEY_IDX_W-1:0]   key_ff, key_in;
   logic [NIB_W-1:0]       tens_ff, tens_in;
   logic [NIB_W-1:0]       high_ff, high_in;
   logic                   err_ff, err_in;

   phase_type              ph;
   logic [KEY_IDX_W-1:0]   k;
   logic [NIB_W-1:0]       tens;
   logic [NIB_W-1:0]       hi;
   logic                   el;
   logic [CHAR_W-1:0]      c;
   logic                   fin;
   logic [CHAR_W-1:0]      dval;
   logic [NIB_W:0]         hv;
   logic                   bad;
   logic                   end_seq;
   logic [KEY_IDX_W-1:0]   seed_red;
   logic [KEY_IDX_W-1:0]   seed_tens;
   logic [KEY_IDX_W-1:0]   seed_units;
   logic                   need_seed;
   logic [KEY_IDX_W-1:0]   ke;
   logic [CHAR_W-1:0]      code;

   always_comb begin
      // a first marker restarts the sequence before the character is handled
      ph    = item.first ? PH_TENS : phase_ff;
      k     = item.first ? '0 : key_ff;
      tens  = item.first ? '0 : tens_ff;
      hi    = item.first ? '0 : high_ff;
      el    = item.first ? 1'b0 : err_ff;
      c     = item.char_in;
      fin   = item.final_item;
      dval  = c - ASCII_0;
      hv    = hex_val(c);
      bad   = 1'b0;
      end_seq = 1'b0;

      seed_red   = (seed >= KEY_LEN) ? seed - KEY_LEN : seed;
      seed_tens  = (seed_red >= 5'd20) ? 5'd2 : ((seed_red >= 5'd10) ? 5'd1 : 5'd0);
      seed_units = seed_red - seed_tens * 5'd10;
      need_seed  = (ph != PH_HIGH);
      ke         = need_seed ? seed_red : k;
      code       = c ^ key_at(ke);

      phase_in = ph;
      key_in   = k;
      tens_in  = tens;
      high_in  = hi;
      err_in   = el;
      bundle   = '0;

      if (mode == MODE_ENCODE) begin
         if (need_seed) begin
            bundle.items[0].char_out = {3'd0, seed_tens} + ASCII_0;
            bundle.items[1].char_out = {3'd0, seed_units} + ASCII_0;
            bundle.items[2].char_out = hex_char(code[7:4]);
            bundle.items[3].char_out = hex_char(code[3:0]);
            bundle.items[3].done_res = fin;
            bundle.cnt = 3'd4;
         end else begin
            bundle.items[0].char_out = hex_char(code[7:4]);
            bundle.items[1].char_out = hex_char(code[3:0]);
            bundle.items[1].done_res = fin;
            bundle.cnt = 3'd2;
         end
         key_in   = step_key(ke);
         phase_in = PH_HIGH;
         end_seq  = fin;
      end else if (el) begin
         // string already failed: stay quiet until its last character
         if (fin) begin
            bundle.items[0].error    = 1'b1;
            bundle.items[0].done_res = 1'b1;
            bundle.cnt = 3'd1;
            end_seq = 1'b1;
         end
      end else begin
         case (ph)
            PH_TENS: begin
               if (is_digit(c)) begin
                  tens_in  = dval[NIB_W-1:0];
                  phase_in = PH_UNITS;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_UNITS: begin
               if (is_digit(c)) begin
                  key_in   = mod26({4'd0, tens} * 8'd10 + {4'd0, dval[NIB_W-1:0]});
                  phase_in = PH_HIGH;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_HIGH: begin
               if (!hv[NIB_W]) begin
                  high_in  = hv[NIB_W-1:0];
                  phase_in = PH_LOW;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_LOW: begin
               if (!hv[NIB_W]) begin
                  bundle.items[0].char_out = {hi, hv[NIB_W-1:0]} ^ key_at(k);
                  bundle.cnt = 3'd1;
                  key_in   = step_key(k);
                  phase_in = PH_HIGH;
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
               bad = 1'b1;
            end
         endcase

         if (bad) begin
            bundle = '0;
            bundle.items[0].error    = 1'b1;
            bundle.items[0].done_res = fin;
            bundle.cnt = 3'd1;
            err_in  = 1'b1;
            end_seq = fin;
         end else if (fin) begin
            end_seq = 1'b1;
            if (phase_in == PH_HIGH) begin
               // even length: mark the byte, or report an empty password
               bundle.items[0].done_res = 1'b1;
               bundle.cnt = 3'd1;
            end else begin
               // odd length or incomplete seed
               bundle.items[0].error    = 1'b1;
               bundle.items[0].done_res = 1'b1;
               bundle.cnt = 3'd1;
            end
         end
      end

      if (end_seq) begin
         phase_in = PH_TENS;
         key_in   = '0;
         tens_in  = '0;
         high_in  = '0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff <= PH_TENS;
         key_ff   <= '0;
         tens_ff  <= '0;
         high_ff  <= '0;
         err_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         key_ff   <= key_in;
         tens_ff  <= tens_in;
         high_ff  <= high_in;
         err_ff   <= err_in;
      end
   end

endmodule

>>> hdl/t7x_rsp_buf.sv
// ----------------------------------------------------------------------------
// t7x_rsp_buf
// Result register: one character's results, drained one a cycle while ready.
// ----------------------------------------------------------------------------
module t7x_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  t7x_pkg::rsp_bundle_type bundle,
   output logic                    can_load,
   t7x_rsp_if.source               rsp
);
   import t7x_pkg::*;

   logic                        valid_ff, valid_in;
   logic [RSP_CNT_W-1:0]        cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0]        ptr_ff, ptr_in;
   rsp_item_type [MAX_RSP-1:0]  items_ff, items_in;
   logic [RSP_CNT_W-1:0]        last_idx;
   logic                        at_last;
   logic                        take;

   always_comb begin
      last_idx = cnt_ff - 3'd1;
      at_last  = (ptr_ff == last_idx[RSP_PTR_W-1:0]);
      take     = valid_ff && rsp.ready;
      can_load = !valid_ff || (take && at_last);

      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      items_in = items_ff;
      if (load && bundle.cnt != '0) begin
         valid_in = 1'b1;
         cnt_in   = bundle.cnt;
         ptr_in   = '0;
         items_in = bundle.items;
      end else if (take && at_last) begin
         valid_in = 1'b0;
      end else if (take) begin
         ptr_in = ptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         ptr_ff   <= ptr_in;
      end
      items_ff <= items_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.char_out = items_ff[ptr_ff].char_out;
   assign rsp.error    = items_ff[ptr_ff].error;
   assign rsp.done_res = items_ff[ptr_ff].done_res;
   assign rsp.run_last = at_last;

endmodule

>>> hdl/type7_password_xor_codec_top.sv
// ----------------------------------------------------------------------------
// type7_password_xor_codec_top
// Streaming type-7 style password codec with a fixed 26-byte XOR key table.
//
//   channel  | dir | handshake    | payload
//   req_chan | in  | valid/ready  | char_in[7:0], first, final_item
//   rsp_chan | out | valid/ready  | char_out[7:0], run_last, error, done_res
//   csr_chan | in  | valid/ready  | index (0 mode, 1 encode_seed), data[4:0]
//
// Input register -> decode/encode logic -> result register. Decode: one
// character per cycle while rsp_chan is ready. Encode: two result characters
// per byte (four for the first byte of a string), as the result register
// drains one character per cycle while rsp_chan is ready.
// Synchronous reset clears all control state; no clearing pass is needed.
// csr_chan is always ready; a mode write restarts the sequence.
// ----------------------------------------------------------------------------
module type7_password_xor_codec_top (
   input  logic       clock,
   input  logic       reset,
   t7x_req_if.sink    req_chan,
   t7x_rsp_if.source  rsp_chan,
   t7x_csr_if.sink    csr_chan
);
   import t7x_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   req_item_type          in_item_ff;
   logic                  mode_ff;
   logic [KEY_IDX_W-1:0]  seed_ff;
   logic                  can_load;
   logic                  fire;
   logic                  req_take;
   logic                  csr_wr;
   logic                  restart;
   rsp_bundle_type        bundle;

   assign fire           = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || can_load;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !fire);

   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid && csr_chan.ready;
   assign restart        = csr_wr && (csr_chan.index == CSR_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_DECODE;
         seed_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr) begin
            case (csr_chan.index)
               CSR_MODE: mode_ff <= csr_chan.data[0];
               CSR_SEED: seed_ff <= csr_chan.data[KEY_IDX_W-1:0];
               default:  mode_ff <= mode_ff;
            endcase
         end
      end
      if (req_take) begin
         in_item_ff.char_in    <= req_chan.char_in;
         in_item_ff.first      <= req_chan.first;
         in_item_ff.final_item <= req_chan.final_item;
      end
   end

   t7x_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .restart (restart),
      .mode    (mode_ff),
      .seed    (seed_ff),
      .item    (in_item_ff),
      .bundle  (bundle)
   );

   t7x_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .bundle   (bundle),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

endmodule

>>> hdl/t7x_checker.sv
// ----------------------------------------------------------------------------
// t7x_checker
// Port-level checks on the result channel of the codec, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module t7x_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [t7x_pkg::CHAR_W-1:0] rsp_char_out,
   input logic                      rsp_run_last,
   input logic                      rsp_error,
   input logic                      rsp_done_res
);

   // stalled transaction holds
   `T7X_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_out) && $stable(rsp_error) && $stable(rsp_done_res) && $stable(rsp_run_last), "rsp changed while stalled")

   `T7X_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_error, rsp_char_out == 8'h00, "error result with nonzero data")

   // end of string is always the last result of its character
   `T7X_ASSERT_IMP(a_done_last, clock, reset, rsp_valid && rsp_done_res, rsp_run_last, "done_res without run_last")

   // an error result is the last result of its character
   `T7X_ASSERT_IMP(a_err_last, clock, reset, rsp_valid && rsp_error, rsp_run_last, "error result not last")

endmodule

bind type7_password_xor_codec_top t7x_checker u_t7x_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_char_out (rsp_chan.char_out),
   .rsp_run_last (rsp_chan.run_last),
   .rsp_error    (rsp_chan.error),
   .rsp_done_res (rsp_chan.done_res)
);

>>> tb/sv/type7_password_xor_codec_top_tb.sv
// ----------------------------------------------------------------------------
// type7_password_xor_codec_top_tb
// Self-checking bench for the type-7 XOR password codec. A directed set of
// strings hits the seed, hex, odd-length and error corners of decode and the
// seed corners of encode. Random cipher text, plain text and noise then run
// under random valid/ready gaps, one long result stall and an idle-free
// stretch. Every result is checked against an in-bench model of the codec.
// ----------------------------------------------------------------------------
module type7_password_xor_codec_top_tb;
   import t7x_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              run_last;
      logic              error;
      logic              done_res;
   } codec_result_t;

   typedef enum int {TXT_CLEAN, TXT_BAD_CHAR, TXT_TRUNCATED} text_flaw_t;

   localparam int IDLE_PCT        = 36;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int SETTLE_CYCLES   = 8;
   localparam int MAX_REPORTS     = 40;
   localparam int KEY_ENTRIES     = 26;

   // key table, entry 0 in the low byte
   localparam logic [KEY_ENTRIES*CHAR_W-1:0] XOR_KEY = {
      8'h42, 8'h55, 8'h53, 8'h48, 8'h65, 8'h4c, 8'h4b, 8'h72, 8'h41, 8'h6d,
      8'h2a, 8'h72, 8'h65, 8'h47, 8'h72, 8'h75, 8'h4f, 8'h63, 8'h5e, 8'h66,
      8'h78, 8'h57, 8'h23, 8'h23, 8'h40, 8'h2a
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   t7x_req_if req_if ();
   t7x_rsp_if rsp_if ();
   t7x_csr_if csr_if ();

   type7_password_xor_codec_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   logic              req_valid_q = 1'b0;
   logic [CHAR_W-1:0] req_char_q  = '0;
   logic              req_first_q = 1'b0;
   logic              req_final_q = 1'b0;
   logic              rsp_ready_q = 1'b0;
   logic              csr_valid_q = 1'b0;
   csr_index_type     csr_index_q = CSR_MODE;
   logic [CSR_DATA_W-1:0] csr_data_q = '0;

   assign req_if.valid      = req_valid_q;
   assign req_if.char_in    = req_char_q;
   assign req_if.first      = req_first_q;
   assign req_if.final_item = req_final_q;
   assign rsp_if.ready      = rsp_ready_q;
   assign csr_if.valid      = csr_valid_q;
   assign csr_if.index      = csr_index_q;
   assign csr_if.data       = csr_data_q;

   // stimulus and expectations
   req_item_type  char_queue[$];
   req_item_type  char_next;
   codec_result_t result_queue[$];
   logic          req_taken = 1'b0;
   logic          steady_flow = 1'b0;
   int            hold_offs_asked = 0;
   int            hold_offs_done = 0;
   int            hold_left = 0;

   // codec model state
   mode_type          cfg_mode = MODE_DECODE;
   logic [4:0]        cfg_seed = '0;
   phase_type         st_phase = PH_TENS;
   logic [4:0]        st_key_idx = '0;
   logic [3:0]        st_tens = '0;
   logic [3:0]        st_high = '0;
   logic              st_err_latched = 1'b0;

   int fail_count = 0;
   int chars_queued = 0;
   int items_taken = 0;
   int results_checked = 0;
   int error_results = 0;
   int decode_strings = 0;
   int encode_strings = 0;

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_REPORTS) $display("mismatch @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic int hex_value(input logic [CHAR_W-1:0] ch);
      if (ch >= ASCII_0 && ch <= ASCII_9) return int'(ch) - int'(ASCII_0);
      if (ch >= ASCII_UA && ch <= ASCII_UF) return int'(ch) - int'(ASCII_UA) + 10;
      if (ch >= ASCII_LA && ch <= ASCII_LF) return int'(ch) - int'(ASCII_LA) + 10;
      return 16;
   endfunction

   function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [3:0] v, input logic lower);
      if (v > 4'd9) return (lower ? ASCII_LA : ASCII_UA) + (8'(v) - 8'd10);
      return ASCII_0 + 8'(v);
   endfunction

   function automatic codec_result_t make_result(input logic [CHAR_W-1:0] ch,
                                                 input logic err, input logic done);
      codec_result_t r;
      r.char_out = ch;
      r.run_last = 1'b0;
      r.error    = err;
      r.done_res = done;
      return r;
   endfunction

   function automatic logic [4:0] next_key(input logic [4:0] idx);
      return (idx == 5'(KEY_ENTRIES - 1)) ? 5'd0 : idx + 5'd1;
   endfunction

   task automatic restart_codec();
      st_phase       = PH_TENS;
      st_key_idx     = '0;
      st_tens        = '0;
      st_high        = '0;
      st_err_latched = 1'b0;
   endtask

   task automatic predict_codec(input logic [CHAR_W-1:0] c, input logic fst, input logic fin);
      codec_result_t outs[$];
      logic [CHAR_W-1:0] code;
      logic bad;
      int nib;
      int seed;
      if (fst) restart_codec();
      if (cfg_mode == MODE_ENCODE) begin
         if (st_phase != PH_HIGH) begin
            seed = int'(cfg_seed) % KEY_ENTRIES;
            outs.push_back(make_result(ASCII_0 + 8'(seed / 10), 1'b0, 1'b0));
            outs.push_back(make_result(ASCII_0 + 8'(seed % 10), 1'b0, 1'b0));
            st_key_idx = 5'(seed);
            st_phase   = PH_HIGH;
         end
         code = c ^ XOR_KEY[int'(st_key_idx)*CHAR_W +: CHAR_W];
         st_key_idx = next_key(st_key_idx);
         outs.push_back(make_result(nibble_ascii(code[7:4], 1'b0), 1'b0, 1'b0));
         outs.push_back(make_result(nibble_ascii(code[3:0], 1'b0), 1'b0, fin));
         if (fin) restart_codec();
      end else if (st_err_latched) begin
         // rest of a broken string is swallowed until its end
         if (fin) begin
            outs.push_back(make_result('0, 1'b1, 1'b1));
            restart_codec();
         end
      end else begin
         bad = 1'b0;
         nib = hex_value(c);
         case (st_phase)
            PH_TENS: begin
               if (c >= ASCII_0 && c <= ASCII_9) begin
                  st_tens  = 4'(nib);
                  st_phase = PH_UNITS;
               end else bad = 1'b1;
            end
            PH_UNITS: begin
               if (c >= ASCII_0 && c <= ASCII_9) begin
                  st_key_idx = 5'((int'(st_tens) * 10 + nib) % KEY_ENTRIES);
                  st_phase   = PH_HIGH;
               end else bad = 1'b1;
            end
            PH_HIGH: begin
               if (nib < 16) begin
                  st_high  = 4'(nib);
                  st_phase = PH_LOW;
               end else bad = 1'b1;
            end
            default: begin
               if (nib < 16) begin
                  code = {st_high, 4'(nib)} ^ XOR_KEY[int'(st_key_idx)*CHAR_W +: CHAR_W];
                  outs.push_back(make_result(code, 1'b0, 1'b0));
                  st_key_idx = next_key(st_key_idx);
                  st_phase   = PH_HIGH;
               end else bad = 1'b1;
            end
         endcase
         if (bad) begin
            outs.push_back(make_result('0, 1'b1, fin));
            st_err_latched = 1'b1;
            if (fin) restart_codec();
         end else if (fin) begin
            if (st_phase != PH_HIGH) outs.push_back(make_result('0, 1'b1, 1'b1));
            else if (outs.size() > 0) outs[outs.size()-1].done_res = 1'b1;
            else outs.push_back(make_result('0, 1'b0, 1'b1));
            restart_codec();
         end
      end
      if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
      foreach (outs[i]) result_queue.push_back(outs[i]);
   endtask

   // result check, input and register transaction capture
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin : check_rsp
            codec_result_t want;
            if (result_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected result char 0x%02h err %0b done %0b",
                  rsp_if.char_out, rsp_if.error, rsp_if.done_res));
            end else begin
               want = result_queue.pop_front();
               results_checked++;
               if (rsp_if.error) error_results++;
               if (rsp_if.char_out !== want.char_out)
                  report_mismatch($sformatf("char_out 0x%02h, want 0x%02h",
                     rsp_if.char_out, want.char_out));
               if (rsp_if.run_last !== want.run_last)
                  report_mismatch($sformatf("run_last %0b, want %0b",
                     rsp_if.run_last, want.run_last));
               if (rsp_if.error !== want.error)
                  report_mismatch($sformatf("error %0b, want %0b", rsp_if.error, want.error));
               if (rsp_if.done_res !== want.done_res)
                  report_mismatch($sformatf("done_res %0b, want %0b",
                     rsp_if.done_res, want.done_res));
            end
         end
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            items_taken++;
            predict_codec(req_if.char_in, req_if.first, req_if.final_item);
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_MODE: begin
                  cfg_mode = mode_type'(csr_if.data[0]);
                  restart_codec();
               end
               default: cfg_seed = csr_if.data;
            endcase
         end
      end
   end

   // input driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid_q <= 1'b0;
      end else if (!req_valid_q || req_taken) begin
         if (char_queue.size() > 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
            char_next = char_queue.pop_front();
            req_char_q  <= char_next.char_in;
            req_first_q <= char_next.first;
            req_final_q <= char_next.final_item;
            req_valid_q <= 1'b1;
         end else begin
            req_valid_q <= 1'b0;
         end
      end
   end

   // result ready, with the occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready_q <= 1'b0;
      end else if (hold_offs_done < hold_offs_asked) begin
         hold_offs_done++;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_ready_q <= 1'b0;
      end else begin
         rsp_ready_q <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic push_char(input logic [CHAR_W-1:0] c, input logic fst, input logic fin);
      req_item_type it;
      it.char_in    = c;
      it.first      = fst;
      it.final_item = fin;
      char_queue.push_back(it);
      chars_queued++;
   endtask

   task automatic add_cipher_text(input int nbytes, input text_flaw_t flaw);
      logic [CHAR_W-1:0] txt[$];
      logic [CHAR_W-1:0] v;
      int pos;
      txt.push_back(ASCII_0 + 8'($urandom_range(9)));
      txt.push_back(ASCII_0 + 8'($urandom_range(9)));
      for (int i = 0; i < nbytes; i++) begin
         v = 8'($urandom_range(255));
         txt.push_back(nibble_ascii(v[7:4], 1'($urandom_range(1))));
         txt.push_back(nibble_ascii(v[3:0], 1'($urandom_range(1))));
      end
      if (flaw == TXT_TRUNCATED) begin
         void'(txt.pop_back());
      end else if (flaw == TXT_BAD_CHAR) begin
         pos = $urandom_range(txt.size() - 1);
         if (pos < 2 && $urandom_range(1) == 1) begin
            // hex letter where a seed digit belongs
            v = nibble_ascii(4'($urandom_range(15, 10)), 1'($urandom_range(1)));
         end else begin
            do v = 8'($urandom_range(255)); while (hex_value(v) < 16);
         end
         txt[pos] = v;
      end
      foreach (txt[i])
         push_char(txt[i], i == 0 && $urandom_range(9) != 0, i == txt.size() - 1);
      decode_strings++;
   endtask

   task automatic add_plain_text(input int nbytes);
      for (int i = 0; i < nbytes; i++)
         push_char(8'($urandom_range(255)), i == 0, i == nbytes - 1);
      encode_strings++;
   endtask

   task automatic add_noise(input int n);
      for (int i = 0; i < n; i++)
         push_char(8'($urandom_range(255)), $urandom_range(3) == 0, $urandom_range(3) == 0);
   endtask

   task automatic add_random_cipher_mix(input int target);
      int r;
      text_flaw_t flaw;
      target = chars_queued + target;
      while (chars_queued < target) begin
         if ($urandom_range(4) == 0) begin
            add_noise($urandom_range(4, 1));
         end else begin
            r = $urandom_range(99);
            flaw = (r < 70) ? TXT_CLEAN : (r < 85) ? TXT_BAD_CHAR : TXT_TRUNCATED;
            add_cipher_text(($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(4),
                            flaw);
         end
      end
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid_q = 1'b1;
      csr_index_q = idx;
      csr_data_q  = val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_valid_q = 1'b0;
      @(posedge clock);
   endtask

   // everything offered, accepted and answered, then a short settle
   task automatic wait_idle();
      while (char_queue.size() != 0 || req_valid_q || result_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      #400000;
      $display("timeout with %0d results outstanding", result_queue.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      int target;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed decode corners
      csr_write(CSR_MODE, CSR_DATA_W'(MODE_DECODE));
      csr_write(CSR_SEED, 5'd0);
      push_char("9", 1'b1, 1'b0);             // seed 99 wraps to 21
      push_char("9", 1'b0, 1'b0);
      push_char("F", 1'b0, 1'b0);
      push_char("f", 1'b0, 1'b0);
      push_char("0", 1'b0, 1'b0);
      push_char("0", 1'b0, 1'b1);
      push_char("0", 1'b1, 1'b0);             // empty password
      push_char("7", 1'b0, 1'b1);
      push_char(8'hff, 1'b1, 1'b0);           // bad seed char, rest swallowed
      push_char("1", 1'b0, 1'b0);
      push_char("2", 1'b0, 1'b1);
      push_char("1", 1'b1, 1'b1);             // incomplete seed
      push_char("1", 1'b1, 1'b0);             // unpaired hex char
      push_char("2", 1'b0, 1'b0);
      push_char("A", 1'b0, 1'b1);
      push_char("0", 1'b1, 1'b0);             // bad hex char
      push_char("0", 1'b0, 1'b0);
      push_char("g", 1'b0, 1'b0);
      push_char(8'h00, 1'b0, 1'b1);
      wait_idle();

      // directed encode: out-of-range seed, then the top legal seed
      csr_write(CSR_MODE, CSR_DATA_W'(MODE_ENCODE));
      csr_write(CSR_SEED, 5'd31);
      push_char(8'h00, 1'b1, 1'b0);
      push_char(8'hff, 1'b0, 1'b1);
      wait_idle();
      csr_write(CSR_SEED, 5'd25);
      push_char(8'ha5, 1'b1, 1'b1);
      wait_idle();

      // random cipher text with flaws and noise
      csr_write(CSR_MODE, CSR_DATA_W'(MODE_DECODE));
      add_random_cipher_mix(70);
      wait_idle();

      // random plain text over several seeds; first round stalls the results
      csr_write(CSR_MODE, CSR_DATA_W'(MODE_ENCODE));
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: csr_write(CSR_SEED, 5'd0);
            1: csr_write(CSR_SEED, 5'($urandom_range(24, 1)));
            2: csr_write(CSR_SEED, 5'($urandom_range(31, 26)));
            default: csr_write(CSR_SEED, 5'($urandom_range(31)));
         endcase
         target = chars_queued + 13;
         while (chars_queued < target) begin
            if ($urandom_range(9) == 0) add_noise($urandom_range(2, 1));
            else add_plain_text($urandom_range(4, 1));
         end
         if (s == 0) hold_offs_asked++;
         wait_idle();
      end

      // back-to-back decode with no gaps on either side
      csr_write(CSR_MODE, CSR_DATA_W'(MODE_DECODE));
      steady_flow = 1'b1;
      add_random_cipher_mix(40);
      wait_idle();
      steady_flow = 1'b0;

      if (result_queue.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", result_queue.size()));
      $display("ran %0d decode and %0d encode strings, %0d input transactions",
               decode_strings, encode_strings, items_taken);
      $display("checked %0d results, %0d flagged as errors, %0d mismatches",
               results_checked, error_results, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/t7x_pkg.sv
hdl/t7x_req_if.sv
hdl/t7x_rsp_if.sv
hdl/t7x_csr_if.sv
hdl/t7x_engine.sv
hdl/t7x_rsp_buf.sv
hdl/type7_password_xor_codec_top.sv
hdl/t7x_checker.sv
tb/sv/type7_password_xor_codec_top_tb.sv
